/* hdl/css_pkg.sv */
package css_pkg;

  localparam int unsigned MaxDepthDefault = 16;
  localparam int unsigned MaxArgsDefault = 16;

  localparam int unsigned ModeW = 3;
  localparam int unsigned CountW = 5;
  localparam int unsigned PosW = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned NestW = 5;
  localparam int unsigned ScopeW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_IF       = 3'd0,
    MODE_IFNOT    = 3'd1,
    MODE_ELSIF    = 3'd2,
    MODE_ELSIFNOT = 3'd3,
    MODE_ELSE     = 3'd4,
    MODE_ENDIF    = 3'd5
  } mode_t;

  typedef enum logic [ScopeW-1:0] {
    SCOPE_OPEN     = 2'd0,
    SCOPE_DEFERRED = 2'd1,
    SCOPE_CLOSED   = 2'd2
  } scope_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK   = 3'd0,
    ST_ARGS = 3'd1,
    ST_NOIF = 3'd2,
    ST_EVAL = 3'd3,
    ST_OVER = 3'd4
  } status_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CountW-1:0] arg_count;
    logic [PosW-1:0]   first_true_pos;
    logic [PosW-1:0]   first_false_pos;
    logic [PosW-1:0]   first_error_pos;
  } dir_t;

  typedef struct packed {
    status_t          status;
    logic             text_enabled;
    logic [NestW-1:0] nest_depth;
  } res_t;

endpackage

/* hdl/css_if.sv */
interface css_dir_if;
  logic                        valid;
  logic                        ready;
  logic [css_pkg::ModeW-1:0]   mode;
  logic [css_pkg::CountW-1:0]  arg_count;
  logic [css_pkg::PosW-1:0]    first_true_pos;
  logic [css_pkg::PosW-1:0]    first_false_pos;
  logic [css_pkg::PosW-1:0]    first_error_pos;

  modport source (
    output valid, mode, arg_count, first_true_pos, first_false_pos, first_error_pos,
    input  ready
  );
  modport sink (
    input  valid, mode, arg_count, first_true_pos, first_false_pos, first_error_pos,
    output ready
  );
endinterface

interface css_res_if;
  logic                        valid;
  logic                        ready;
  logic [css_pkg::StatusW-1:0] status;
  logic                        text_enabled;
  logic [css_pkg::NestW-1:0]   nest_depth;

  modport source (
    output valid, status, text_enabled, nest_depth,
    input  ready
  );
  modport sink (
    input  valid, status, text_enabled, nest_depth,
    output ready
  );
endinterface

/* hdl/css_ram.sv */
module css_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/css_core.sv */
module css_core #(
  parameter int unsigned MAX_DEPTH = css_pkg::MaxDepthDefault,
  parameter int unsigned MAX_ARGS  = css_pkg::MaxArgsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  css_pkg::dir_t dir,
  output css_pkg::res_t res
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = $clog2(MAX_DEPTH);

  // The top scope lives in a register; the scopes below it live in the RAM.
  // The RAM is read every cycle at the entry just below the next top, so a
  // pop finds its new top already waiting in the registered read data.
  logic [DW-1:0]   depth, depth_next;
  css_pkg::scope_t top, top_next;
  logic            fwd;
  css_pkg::scope_t fwd_data;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [css_pkg::ScopeW-1:0]  ram_rdata;

  css_pkg::scope_t  below, push_val;
  css_pkg::status_t status;
  logic             push_req, top_open, bad_count, has_mis, has_err, eval_err;
  logic [css_pkg::PosW-1:0] mis;

  css_ram #(
    .WIDTH(css_pkg::ScopeW),
    .DEPTH(MAX_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(top),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    below = fwd ? fwd_data : css_pkg::scope_t'(ram_rdata);
    top_open = (depth == '0) || (top == css_pkg::SCOPE_OPEN);
    bad_count = (dir.arg_count == '0) || ({2'b00, dir.arg_count} > 7'(MAX_ARGS));
    mis = (dir.mode == css_pkg::MODE_IF || dir.mode == css_pkg::MODE_ELSIF)
          ? dir.first_false_pos : dir.first_true_pos;
    has_mis = mis < dir.arg_count;
    has_err = dir.first_error_pos < dir.arg_count;
    eval_err = has_err && (!has_mis || dir.first_error_pos <= mis);

    depth_next = depth;
    top_next = top;
    status = css_pkg::ST_OK;
    push_req = 1'b0;
    push_val = css_pkg::SCOPE_CLOSED;
    ram_we = 1'b0;

    if (fire) begin
      unique case (css_pkg::mode_t'(dir.mode)) inside
        css_pkg::MODE_IF, css_pkg::MODE_IFNOT: begin
          if (bad_count) begin
            status = css_pkg::ST_ARGS;
          end else if (!top_open) begin
            push_req = 1'b1;
          end else if (eval_err) begin
            status = css_pkg::ST_EVAL;
          end else begin
            push_req = 1'b1;
            push_val = has_mis ? css_pkg::SCOPE_DEFERRED : css_pkg::SCOPE_OPEN;
          end
        end
        css_pkg::MODE_ELSIF, css_pkg::MODE_ELSIFNOT: begin
          if (bad_count) begin
            status = css_pkg::ST_ARGS;
          end else if (depth == '0) begin
            status = css_pkg::ST_NOIF;
          end else if (top == css_pkg::SCOPE_OPEN) begin
            top_next = css_pkg::SCOPE_CLOSED;
          end else if (top == css_pkg::SCOPE_DEFERRED) begin
            if (eval_err) begin
              status = css_pkg::ST_EVAL;
            end else if (!has_mis) begin
              top_next = css_pkg::SCOPE_OPEN;
            end
          end
        end
        css_pkg::MODE_ELSE: begin
          if (dir.arg_count != '0) begin
            status = css_pkg::ST_ARGS;
          end else if (depth == '0) begin
            status = css_pkg::ST_NOIF;
          end else if (top == css_pkg::SCOPE_OPEN) begin
            top_next = css_pkg::SCOPE_CLOSED;
          end else if (top == css_pkg::SCOPE_DEFERRED) begin
            top_next = css_pkg::SCOPE_OPEN;
          end
        end
        css_pkg::MODE_ENDIF: begin
          if (dir.arg_count != '0) begin
            status = css_pkg::ST_ARGS;
          end else if (depth == '0) begin
            status = css_pkg::ST_NOIF;
          end else begin
            depth_next = depth - DW'(1);
            top_next = below;
          end
        end
        default: begin
        end
      endcase

      if (push_req) begin
        if (depth == DW'(MAX_DEPTH)) begin
          status = css_pkg::ST_OVER;
        end else begin
          depth_next = depth + DW'(1);
          top_next = push_val;
          ram_we = (depth != '0);
        end
      end
    end

    ram_waddr = AW'(depth - DW'(1));
    ram_raddr = AW'(depth_next - DW'(2));

    res.status = status;
    res.text_enabled = (depth_next == '0) || (top_next == css_pkg::SCOPE_OPEN);
    res.nest_depth = css_pkg::NestW'(depth_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      top <= css_pkg::SCOPE_OPEN;
      fwd <= 1'b0;
    end else begin
      depth <= depth_next;
      top <= top_next;
      fwd <= ram_we && (ram_waddr == ram_raddr);
    end
    fwd_data <= top;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_DEPTH))
    else $error("stack depth beyond capacity");

  a_fwd_after_push: assert property (@(posedge clk) disable iff (rst)
    fwd |-> depth >= DW'(2))
    else $error("forwarding without a stored entry below the top");

  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(depth))
    else $error("stack depth changed without a request");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    fire && status == css_pkg::ST_OVER |-> depth == DW'(MAX_DEPTH))
    else $error("overflow reported below capacity");

endmodule

/* hdl/css_obuf.sv */
module css_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  css_pkg::res_t in_res,
  css_res_if.source     result
);

  logic          out_valid, skid_valid;
  css_pkg::res_t out_res, skid_res;
  logic          take;

  assign in_ready = !skid_valid;
  assign take = out_valid && result.ready;

  assign result.valid = out_valid;
  assign result.status = out_res.status;
  assign result.text_enabled = out_res.text_enabled;
  assign result.nest_depth = out_res.nest_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take) begin
          out_valid <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_valid) begin
        if (!out_valid || take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
    if (skid_valid) begin
      if (take) begin
        out_res <= skid_res;
      end
    end else if (in_valid) begin
      if (!out_valid || take) begin
        out_res <= in_res;
      end else begin
        skid_res <= in_res;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result.ready |=> skid_valid && $stable(skid_res))
    else $error("skid entry lost while output stalled");

endmodule

/* hdl/conditional_scope_stack.sv */
// A request's result is registered in a two-entry output buffer, which keeps accepting
// while one result waits to be taken. One request per cycle while the buffer has room;
// the top scope is held in a register and the scope RAM is read one entry ahead, so
// back-to-back pushes and pops run at full rate.
// Reset (synchronous, active high) empties the stack; the scope RAM is not cleared.
module conditional_scope_stack #(
  parameter int unsigned MAX_DEPTH = css_pkg::MaxDepthDefault,
  parameter int unsigned MAX_ARGS  = css_pkg::MaxArgsDefault
) (
  input logic       clk,
  input logic       rst,
  css_dir_if.sink   directive,
  css_res_if.source result
);

  logic          fire, buf_ready;
  css_pkg::dir_t dir;
  css_pkg::res_t res;

  assign directive.ready = buf_ready;
  assign fire = directive.valid && buf_ready;

  assign dir.mode = directive.mode;
  assign dir.arg_count = directive.arg_count;
  assign dir.first_true_pos = directive.first_true_pos;
  assign dir.first_false_pos = directive.first_false_pos;
  assign dir.first_error_pos = directive.first_error_pos;

  css_core #(
    .MAX_DEPTH(MAX_DEPTH),
    .MAX_ARGS (MAX_ARGS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .dir (dir),
    .res (res)
  );

  css_obuf u_obuf (
    .clk     (clk),
    .rst     (rst),
    .in_valid(fire),
    .in_ready(buf_ready),
    .in_res  (res),
    .result  (result)
  );

endmodule
